@@ rtl/bdcc_pkg.sv @@
// Shared constants for the button debounce and click classifier.
package bdcc_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned EVENT_W = 2;
    localparam int unsigned COUNT_W = 2;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned DATA_W  = 32;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = CFG_W'(50);
    localparam logic [CFG_W-1:0] WINDOW_RESET   = CFG_W'(500);

    localparam logic [EVENT_W-1:0] EVENT_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EVENT_SINGLE = 2'd1;
    localparam logic [EVENT_W-1:0] EVENT_DOUBLE = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 2'd3;

    // Register index, taken from paddr word bit
    localparam logic REG_DEBOUNCE = 1'b0;
    localparam logic REG_WINDOW   = 1'b1;

endpackage

@@ rtl/button_debounce_click_classifier_core.sv @@
// Button debounce and single/double click classifier, top level.
//
// Each transfer on the input channel carries one sample of the raw button
// level and a free-running millisecond timestamp; each sample yields exactly
// one result transfer with the click event (none, single, double-or-more)
// and the debounced level after that sample. All time differences are
// modulo 2^32, so the timestamp may wrap. A raw level change restarts the
// debounce timer; a level held strictly longer than debounce_ms becomes
// the debounced level. Debounced rising edges count presses (saturating at
// 3); once more than click_window_ms has passed since the first press the
// group is reported and the count clears. Two registers stand between input
// and output: the sample lands in the input register when it is taken, and
// compare and subtract logic feeds the result register, which also updates
// the tracking state, when that item moves on; the input register holds it
// while the output is stalled. A new sample can be taken every cycle while
// the output is not stalled; throughput is one item per clock, limited
// only by the output stall. Registers (APB, 32-bit data, pready always
// high): 0x0 debounce_ms, 0x4 click_window_ms, low 16 bits kept. Write
// configuration only while the block is idle.
module button_debounce_click_classifier_core
    import bdcc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_raw_level,
    input  logic [TIME_W-1:0]  i_time_ms,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [EVENT_W-1:0] o_click_event,
    output logic               o_stable_level,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    // configuration registers
    logic [CFG_W-1:0] r_debounce_ms;
    logic [CFG_W-1:0] r_window_ms;
    logic             cfg_wr;

    // input stage
    logic              r_s1_valid;
    logic              r_s1_raw;
    logic [TIME_W-1:0] r_s1_time;

    // tracking state
    logic               r_debounced;
    logic               r_prev_raw;
    logic [TIME_W-1:0]  r_last_change;
    logic [COUNT_W-1:0] r_press_count;
    logic [TIME_W-1:0]  r_first_press;

    // result stage
    logic               r_out_valid;
    logic [EVENT_W-1:0] r_event;
    logic               r_stable;

    // next-state values
    logic               n_debounced;
    logic [TIME_W-1:0]  n_last_change;
    logic [COUNT_W-1:0] n_press_count;
    logic [TIME_W-1:0]  n_first_press;
    logic [EVENT_W-1:0] n_event;
    logic [TIME_W-1:0]  since_change;
    logic [TIME_W-1:0]  since_first;
    logic [COUNT_W-1:0] count_after_press;

    logic adv_out;
    logic take_in;

    // ---------------------------------------------------------------
    // APB: write on access phase, read mux is combinational
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= DEBOUNCE_RESET;
            r_window_ms   <= WINDOW_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_DEBOUNCE) begin
                r_debounce_ms <= pwdata[CFG_W-1:0];
            end else begin
                r_window_ms <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_WINDOW) begin
            prdata = {{(DATA_W-CFG_W){1'b0}}, r_window_ms};
        end else begin
            prdata = {{(DATA_W-CFG_W){1'b0}}, r_debounce_ms};
        end
    end

    // ---------------------------------------------------------------
    // Flow control: result register moves when empty or taken;
    // input register refills whenever its item moves on.
    // ---------------------------------------------------------------
    assign adv_out    = r_s1_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_s1_valid & ~adv_out;
    assign take_in    = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (take_in) begin
            r_s1_valid <= 1'b1;
        end else if (adv_out) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_s1_raw  <= i_raw_level;
            r_s1_time <= i_time_ms;
        end
    end

    // ---------------------------------------------------------------
    // Debounce and click classification for the sample in stage 1
    // ---------------------------------------------------------------
    always_comb begin
        n_last_change = (r_s1_raw != r_prev_raw) ? r_s1_time : r_last_change;
        since_change  = r_s1_time - n_last_change;

        n_debounced   = r_debounced;
        n_press_count = r_press_count;
        n_first_press = r_first_press;

        count_after_press = (r_press_count == COUNT_MAX) ? r_press_count
                                                         : r_press_count + 2'd1;

        // level held strictly longer than the debounce delay
        if (since_change > {{(TIME_W-CFG_W){1'b0}}, r_debounce_ms}) begin
            if (r_s1_raw != r_debounced) begin
                n_debounced = r_s1_raw;
                if (r_s1_raw) begin
                    if (r_press_count == '0) begin
                        n_first_press = r_s1_time;
                    end
                    n_press_count = count_after_press;
                end
            end
        end

        // window test sees a press accepted on this same sample
        since_first = r_s1_time - n_first_press;
        n_event     = EVENT_NONE;
        if ((n_press_count != '0) &&
            (since_first > {{(TIME_W-CFG_W){1'b0}}, r_window_ms})) begin
            n_event       = (n_press_count == 2'd1) ? EVENT_SINGLE : EVENT_DOUBLE;
            n_press_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounced   <= 1'b0;
            r_prev_raw    <= 1'b0;
            r_last_change <= '0;
            r_press_count <= '0;
            r_first_press <= '0;
        end else if (adv_out) begin
            r_debounced   <= n_debounced;
            r_prev_raw    <= r_s1_raw;
            r_last_change <= n_last_change;
            r_press_count <= n_press_count;
            r_first_press <= n_first_press;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= 1'b1;
        end else if (~i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out) begin
            r_event  <= n_event;
            r_stable <= n_debounced;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_click_event  = r_event;
    assign o_stable_level = r_stable;

endmodule

@@ bench/button_debounce_click_classifier_core_test.sv @@
// Self-checking bench for the button debounce and click classifier core.
module button_debounce_click_classifier_core_test
    import bdcc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // One pin sample as queued for the driver. Directed rows may carry a
    // hand-written expectation (typed = 1) that overrides the predictor.
    typedef struct packed {
        logic               raw;
        logic [TIME_W-1:0]  stamp;
        bit                 typed;
        logic [EVENT_W-1:0] ev;
        logic               lvl;
    } t_sample;

    typedef struct packed {
        logic [EVENT_W-1:0] click;
        logic               level;
    } t_click_result;

    localparam int unsigned PHASE_ITEMS = 126;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    logic               i_raw_level = 1'b0;
    logic [TIME_W-1:0]  i_time_ms   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [EVENT_W-1:0] o_click_event;
    logic               o_stable_level;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [ADDR_W-1:0]  paddr       = '0;
    logic [DATA_W-1:0]  pwdata      = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    button_debounce_click_classifier_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_raw_level    (i_raw_level),
        .i_time_ms      (i_time_ms),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_click_event  (o_click_event),
        .o_stable_level (o_stable_level),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Queues: samples waiting to be driven, samples on the bus not yet
    // transferred, and predicted results not yet seen on the output.
    t_sample       pin_samples[$];
    t_sample       sent_samples[$];
    t_click_result pending_results[$];

    int unsigned mismatch_count = 0;
    bit          no_idle        = 1'b0;

    // Predictor copy of the configuration and tracking state, reset values.
    logic [CFG_W-1:0]   cfg_debounce   = DEBOUNCE_RESET;
    logic [CFG_W-1:0]   cfg_window     = WINDOW_RESET;
    logic               st_level       = 1'b0;
    logic               st_prev_raw    = 1'b0;
    logic [TIME_W-1:0]  st_last_change = '0;
    logic [COUNT_W-1:0] st_presses     = '0;
    logic [TIME_W-1:0]  st_first_press = '0;

    // Generator view of the pin: running timestamp and current level.
    logic [TIME_W-1:0] gen_stamp = '0;
    logic              gen_level = 1'b0;

    // Directed rows, default timing (50 ms debounce, 500 ms window).
    // Typed rows hold results that follow directly from the reset state.
    t_sample directed_rows [22] = '{
        '{1'b0, 32'd0,          1'b1, EVENT_NONE,   1'b0}, // idle pin after reset
        '{1'b1, 32'd10,         1'b1, EVENT_NONE,   1'b0}, // change never taken same sample
        '{1'b1, 32'd61,         1'b1, EVENT_NONE,   1'b1}, // 51 ms held: first press
        '{1'b0, 32'd70,         1'b0, EVENT_NONE,   1'b0},
        '{1'b0, 32'd121,        1'b0, EVENT_NONE,   1'b0},
        '{1'b1, 32'd130,        1'b0, EVENT_NONE,   1'b0},
        '{1'b1, 32'd181,        1'b0, EVENT_NONE,   1'b0}, // second press
        '{1'b0, 32'd200,        1'b0, EVENT_NONE,   1'b0},
        '{1'b0, 32'd251,        1'b0, EVENT_NONE,   1'b0},
        '{1'b1, 32'd260,        1'b0, EVENT_NONE,   1'b0},
        '{1'b1, 32'd311,        1'b0, EVENT_NONE,   1'b0}, // third press
        '{1'b0, 32'd320,        1'b0, EVENT_NONE,   1'b0},
        '{1'b0, 32'd371,        1'b0, EVENT_NONE,   1'b0},
        '{1'b1, 32'd380,        1'b0, EVENT_NONE,   1'b0},
        '{1'b1, 32'd431,        1'b0, EVENT_NONE,   1'b0}, // fourth press, count saturated
        '{1'b0, 32'd440,        1'b0, EVENT_NONE,   1'b0},
        '{1'b0, 32'd491,        1'b0, EVENT_NONE,   1'b0},
        '{1'b0, 32'd562,        1'b1, EVENT_DOUBLE, 1'b0}, // 501 ms past first press
        '{1'b1, 32'hFFFF_FFF0,  1'b0, EVENT_NONE,   1'b0}, // press across the wrap
        '{1'b1, 32'h0000_0023,  1'b0, EVENT_NONE,   1'b0},
        '{1'b0, 32'h0000_0030,  1'b0, EVENT_NONE,   1'b0},
        '{1'b0, 32'h0000_0300,  1'b1, EVENT_SINGLE, 1'b0}  // release and single click
    };

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("button_debounce_click_classifier_core_test failed");
        $finish;
    end

    // Expected result for one transferred sample; advances predictor state.
    // Debounce first, so a press taken on this sample counts before the
    // window test on the same sample.
    function automatic t_click_result classify_sample(input logic raw,
                                                      input logic [TIME_W-1:0] now);
        t_click_result     r;
        logic [TIME_W-1:0] since;
        r.click = EVENT_NONE;
        if (raw != st_prev_raw)
            st_last_change = now;
        since = now - st_last_change;
        if (since > TIME_W'(cfg_debounce) && raw != st_level) begin
            st_level = raw;
            if (raw) begin
                if (st_presses == '0)
                    st_first_press = now;
                if (st_presses < COUNT_MAX)
                    st_presses = st_presses + 2'd1;
            end
        end
        st_prev_raw = raw;
        since = now - st_first_press;
        if (st_presses != '0 && since > TIME_W'(cfg_window)) begin
            r.click = (st_presses == 2'd1) ? EVENT_SINGLE : EVENT_DOUBLE;
            st_presses = '0;
        end
        r.level = st_level;
        return r;
    endfunction

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Receiver side: random stall, none during a steady phase.
    always @(posedge i_clk) begin
        i_out_stall <= !no_idle && ($urandom_range(99) < 37);
    end

    // Prediction on input transfers, comparison on output transfers.
    always @(posedge i_clk) begin
        t_sample       s;
        t_click_result want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                s = sent_samples.pop_front();
                want = classify_sample(s.raw, s.stamp);
                if (s.typed) begin
                    want.click = s.ev;
                    want.level = s.lvl;
                end
                pending_results.push_back(want);
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    note_failure($sformatf("unexpected result: event %0d level %0d",
                                           o_click_event, o_stable_level));
                end else begin
                    want = pending_results.pop_front();
                    if (o_click_event !== want.click || o_stable_level !== want.level)
                        note_failure($sformatf(
                            "result mismatch: event exp %0d got %0d, level exp %0d got %0d",
                            want.click, o_click_event, want.level, o_stable_level));
                end
            end
        end
    end

    // One APB transfer: setup cycle, then access until pready.
    task automatic cfg_access(input bit wr, input logic idx,
                              input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write a register, mirror it in the predictor, read it back.
    // Only the low 16 bits are kept by the block.
    task automatic cfg_write(input logic idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] rd;
        cfg_access(1'b1, idx, value, rd);
        if (idx == REG_DEBOUNCE)
            cfg_debounce = value[CFG_W-1:0];
        else
            cfg_window = value[CFG_W-1:0];
        cfg_access(1'b0, idx, '0, rd);
        if (rd !== DATA_W'(value[CFG_W-1:0]))
            note_failure($sformatf("register %0d readback exp %0h got %0h",
                                   idx, value[CFG_W-1:0], rd));
    endtask

    // Sender side: one sample per transfer, random gaps, payload held
    // while stalled. pending tracks a sample on the bus not yet taken.
    task automatic drive_samples();
        bit      pending;
        t_sample s;
        pending = 1'b0;
        while (pin_samples.size() != 0 || pending) begin
            @(posedge i_clk);
            if (pending && !o_in_stall)
                pending = 1'b0;
            if (!pending) begin
                if (pin_samples.size() != 0 && (no_idle || $urandom_range(99) >= 37)) begin
                    s = pin_samples.pop_front();
                    sent_samples.push_back(s);
                    i_in_valid  <= 1'b1;
                    i_raw_level <= s.raw;
                    i_time_ms   <= s.stamp;
                    pending = 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    endtask

    // Wait until every transferred sample has produced its result.
    task automatic settle();
        while (sent_samples.size() != 0 || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_sample(input logic lvl, input logic [TIME_W-1:0] step);
        t_sample s;
        gen_stamp = gen_stamp + step;
        gen_level = lvl;
        s = '{lvl, gen_stamp, 1'b0, EVENT_NONE, 1'b0};
        pin_samples.push_back(s);
    endtask

    // Contact bounce, then hold the level to just around the debounce
    // delay and a little past it, so the strict compare is hit on both sides.
    task automatic settle_level(input logic lvl);
        int unsigned       bounces;
        logic [TIME_W-1:0] hold;
        bounces = $urandom_range(0, 3);
        repeat (bounces) queue_sample(!gen_level, $urandom_range(0, cfg_debounce / 2 + 1));
        queue_sample(lvl, $urandom_range(0, cfg_debounce / 2 + 1));
        hold = cfg_debounce + $urandom_range(0, 2);
        queue_sample(lvl, (hold == '0) ? '0 : hold - 1'b1);
        queue_sample(lvl, $urandom_range(1, 3));
    endtask

    // A group of one to four presses, usually followed by a quiet wait
    // past the click window so the group gets classified.
    task automatic click_burst();
        int unsigned presses;
        presses = $urandom_range(1, 4);
        repeat (presses) begin
            settle_level(1'b1);
            settle_level(1'b0);
        end
        if ($urandom_range(3) != 0)
            queue_sample(1'b0, cfg_window + $urandom_range(0, 2));
    endtask

    // Unstructured samples: random level, steps from tiny to full-range jumps.
    task automatic noise_run();
        int unsigned       count;
        logic [TIME_W-1:0] step;
        count = $urandom_range(1, 6);
        repeat (count) begin
            case ($urandom_range(0, 3))
                0:       step = $urandom();
                1:       step = $urandom_range(0, 3);
                2:       step = cfg_debounce + $urandom_range(0, 1);
                default: step = cfg_window + $urandom_range(0, 1);
            endcase
            queue_sample(1'($urandom_range(0, 1)), step);
        end
    endtask

    task automatic run_phase(input logic [DATA_W-1:0] debounce_val,
                             input logic [DATA_W-1:0] window_val,
                             input bit steady);
        cfg_write(REG_DEBOUNCE, debounce_val);
        cfg_write(REG_WINDOW, window_val);
        gen_stamp = $urandom();
        while (pin_samples.size() < PHASE_ITEMS) begin
            if ($urandom_range(99) < 70)
                click_burst();
            else
                noise_run();
        end
        no_idle = steady;
        drive_samples();
        settle();
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under reset timing values.
        foreach (directed_rows[i])
            pin_samples.push_back(directed_rows[i]);
        drive_samples();
        settle();

        // Random phases. Upper data bits are junk that must be dropped.
        run_phase({16'hABCD, 16'd50}, {16'h5A5A, 16'd500}, 1'b0);
        run_phase(32'd0, 32'd0, 1'b0);
        run_phase(32'h0000_FFFF, 32'hFFFF_FFFF, 1'b0);
        run_phase($urandom_range(1, 200), $urandom_range(100, 1000), 1'b1);
        run_phase({16'($urandom_range(0, 65535)), 16'd20},
                  {16'($urandom_range(0, 65535)), 16'd300}, 1'b0);

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("button_debounce_click_classifier_core_test passed");
        else
            $display("button_debounce_click_classifier_core_test failed");
        $finish;
    end

endmodule
